// ----- hdl/mm_pkg.sv -----
// Shared types and constants for the matrix multiply block.
// Holds command codes, controller states and the controller-to-datapath structs.
// No dependencies.
package mm_pkg;

  localparam int MAX_DIM_DEF    = 16;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int SUM_W          = 40;
  localparam int MAX_RESULTS    = 16;
  localparam int SIZE_W         = 5;
  localparam int IDX_W          = 4;
  localparam int VALUE_W        = 16;
  localparam int CMD_W          = 2;
  localparam int REG_IDX_W      = 2;

  localparam logic [REG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_a;   // write input element into the A store
    logic wr_b;   // write input element into the B store
    logic rd;     // read one A/B pair for the current inner index
    logic clr;    // clear the accumulator
    logic emit;   // move the accumulator into the output register
    logic last;   // flag of the emitted element
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ----- hdl/mm_ctrl.sv -----
// Controller of the matrix multiply block: size registers, command decode
// and the sequencer that walks columns and inner index. Depends on mm_pkg.
module mm_ctrl import mm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CMD_W-1:0]       cmd_i,
  input  logic [IDX_W-1:0]       row_i,
  input  logic [IDX_W-1:0]       col_i,
  input  logic                   cfg_we_i,
  input  logic [REG_IDX_W-1:0]   cfg_index_i,
  input  logic [SIZE_W-1:0]      cfg_wdata_i,
  input  dp_status_t             status_i,
  output ctrl_cmd_t              cmd_o,
  output logic [$clog2(MAX_DIM)-1:0] k_o,
  output logic [IDX_W-1:0]       row_o,
  output logic [IDX_W-1:0]       col_o
);

  localparam int KW     = $clog2(MAX_DIM);
  localparam int ColCap = (MAX_DIM < MAX_RESULTS) ? MAX_DIM : MAX_RESULTS;

  state_e            state_q, state_d;
  logic [KW-1:0]     k_q, k_d;
  logic [IDX_W-1:0]  j_q, j_d;
  logic [IDX_W-1:0]  row_q, row_d;
  logic [SIZE_W-1:0] rows_a_q, inner_len_q, cols_b_q;
  logic [SIZE_W-1:0] nr, nk, nc;
  logic              load_ok, row_ok, last_k, last_j;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= SIZE_W'(16);
      inner_len_q <= SIZE_W'(16);
      cols_b_q    <= SIZE_W'(16);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROWS_A:    rows_a_q    <= cfg_wdata_i;
        REG_INNER_LEN: inner_len_q <= cfg_wdata_i;
        REG_COLS_B:    cols_b_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective sizes after saturation.
  assign nr = (int'(rows_a_q) > MAX_DIM) ? SIZE_W'(MAX_DIM) : rows_a_q;
  assign nk = (int'(inner_len_q) > MAX_DIM) ? SIZE_W'(MAX_DIM) : inner_len_q;
  assign nc = (int'(cols_b_q) > ColCap) ? SIZE_W'(ColCap) : cols_b_q;

  assign load_ok = (int'(row_i) < MAX_DIM) && (int'(col_i) < MAX_DIM);
  assign row_ok  = ({1'b0, row_i} < nr) && (nc != '0);
  assign last_k  = (int'(k_q) + 1) == int'(nk);
  assign last_j  = (int'(j_q) + 1) == int'(nc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      j_q     <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      j_q     <= j_d;
      row_q   <= row_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    j_d        = j_q;
    row_d      = row_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (cmd_e'(cmd_i))
            CMD_LOAD_A: cmd_o.wr_a = load_ok;
            CMD_LOAD_B: cmd_o.wr_b = load_ok;
            CMD_COMPUTE: begin
              if (row_ok) begin
                row_d     = row_i;
                j_d       = '0;
                k_d       = '0;
                cmd_o.clr = 1'b1;
                state_d   = (nk == '0) ? ST_EMIT : ST_ISSUE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        cmd_o.rd = 1'b1;
        if (last_k) begin
          state_d = ST_DRAIN1;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DRAIN1: state_d = ST_DRAIN2;
      ST_DRAIN2: state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = last_j;
          if (last_j) begin
            state_d = ST_IDLE;
          end else begin
            j_d       = j_q + 1'b1;
            k_d       = '0;
            cmd_o.clr = 1'b1;
            state_d   = (nk == '0) ? ST_EMIT : ST_ISSUE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign k_o   = k_q;
  assign row_o = row_q;
  assign col_o = j_q;

  // The pipeline drain always takes both stages.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN1 |=> state_q == ST_DRAIN2)
    else $error("drain sequence broken");

  // A compute for a row outside the result leaves the block idle.
  a_skip_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && cmd_i == CMD_COMPUTE && !row_ok) |=> state_q == ST_IDLE)
    else $error("out-of-range compute started work");

  // The flagged element ends the row.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> state_q == ST_IDLE)
    else $error("row continued after last element");

endmodule

// ----- hdl/mm_dp.sv -----
// Datapath of the matrix multiply block: A and B element stores, the
// multiply-accumulate pipeline and the output register. Depends on mm_pkg.
module mm_dp import mm_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ctrl_cmd_t                    cmd_i,
  input  logic [$clog2(MAX_DIM)-1:0]   k_i,
  input  logic [IDX_W-1:0]             row_i,
  input  logic [IDX_W-1:0]             col_i,
  input  logic [IDX_W-1:0]             load_row_i,
  input  logic [IDX_W-1:0]             load_col_i,
  input  logic signed [VALUE_W-1:0]    value_i,
  output dp_status_t                   status_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [IDX_W-1:0]             out_row_o,
  output logic [IDX_W-1:0]             out_col_o,
  output logic signed [SUM_W-1:0]      out_value_o,
  output logic                         last_o
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AddrW = $clog2(Depth);

  logic [DATA_WIDTH-1:0]          a_mem [Depth];
  logic [DATA_WIDTH-1:0]          b_mem [Depth];
  logic [AddrW-1:0]               wr_addr, a_rd_addr, b_rd_addr;
  logic signed [DATA_WIDTH-1:0]   a_rd_q, b_rd_q;
  logic signed [2*DATA_WIDTH-1:0] prod_full;
  logic signed [SUM_W-1:0]        prod_q, acc_q;
  logic                           rd_v_q, prod_v_q;
  logic                           out_valid_q;
  logic [IDX_W-1:0]               out_row_q, out_col_q;
  logic signed [SUM_W-1:0]        out_value_q;
  logic                           last_q;

  assign wr_addr   = AddrW'(load_row_i) * AddrW'(MAX_DIM) + AddrW'(load_col_i);
  assign a_rd_addr = AddrW'(row_i) * AddrW'(MAX_DIM) + AddrW'(k_i);
  assign b_rd_addr = AddrW'(k_i) * AddrW'(MAX_DIM) + AddrW'(col_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      a_mem[wr_addr] <= DATA_WIDTH'(value_i);
    end
    if (cmd_i.rd) begin
      a_rd_q <= a_mem[a_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_b) begin
      b_mem[wr_addr] <= DATA_WIDTH'(value_i);
    end
    if (cmd_i.rd) begin
      b_rd_q <= b_mem[b_rd_addr];
    end
  end

  assign prod_full = a_rd_q * b_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      rd_v_q   <= cmd_i.rd;
      prod_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      prod_q <= SUM_W'(prod_full);
    end
    if (cmd_i.clr) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + prod_q;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_row_q   <= row_i;
      out_col_q   <= col_i;
      out_value_q <= acc_q;
      last_q      <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign last_o      = last_q;

  // A result is only loaded when the previous one has left.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  // The sum is taken only after the read and product stages are empty.
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!rd_v_q && !prod_v_q))
    else $error("emit with products still in flight");

  // Stores are never written while a dot product is being read.
  a_wr_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_a || cmd_i.wr_b) |-> (!cmd_i.rd && !rd_v_q && !prod_v_q))
    else $error("store written during compute");

endmodule

// ----- hdl/matrix_multiply.sv -----
// Top level of the matrix multiply block C = A x B over signed Q8.8 elements.
// Instantiates mm_ctrl and mm_dp; uses types and constants from mm_pkg.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------
//  input    | in_valid_i / in_ready_o  | cmd_i, row_i, col_i, value_i
//  output   | out_valid_o / out_ready_i| out_row_o, out_col_o, out_value_o, last_o
//  config   | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
// Loads, unused commands and computes that emit nothing are handled in the idle state alone.
// A compute walks nc result columns, nc and nk being the saturated sizes: per column
// nk store reads, a pass through the product and sum registers and one output
// register load (only the load when nk is zero).
// Input ready is low during the walk; a stalled output holds the emit step.
// Reset clears control state and size registers (16 each), not the stores.
module matrix_multiply import mm_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [CMD_W-1:0]          cmd_i,
  input  logic [IDX_W-1:0]          row_i,
  input  logic [IDX_W-1:0]          col_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [IDX_W-1:0]          out_row_o,
  output logic [IDX_W-1:0]          out_col_o,
  output logic signed [SUM_W-1:0]   out_value_o,
  output logic                      last_o,
  input  logic                      cfg_we_i,
  input  logic [REG_IDX_W-1:0]      cfg_index_i,
  input  logic [SIZE_W-1:0]         cfg_wdata_i
);

  // Command and status between the sequencer and the datapath.
  ctrl_cmd_t                  cmd;
  dp_status_t                 status;
  logic [$clog2(MAX_DIM)-1:0] k_idx;
  logic [IDX_W-1:0]           cur_row;
  logic [IDX_W-1:0]           cur_col;

  // The controller decodes each accepted item, holds the size registers
  // and steps the inner index and result column of a compute.
  mm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .k_o         (k_idx),
    .row_o       (cur_row),
    .col_o       (cur_col)
  );

  // The datapath holds both element stores, the multiply-accumulate
  // pipeline and the output register that decouples the result consumer.
  mm_dp #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .k_i         (k_idx),
    .row_i       (cur_row),
    .col_i       (cur_col),
    .load_row_i  (row_i),
    .load_col_i  (col_i),
    .value_i     (value_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_value_o (out_value_o),
    .last_o      (last_o)
  );

endmodule

// ----- verif/mm_checker.sv -----
// Scoreboard for the matrix multiply block: snoops the config, input and output ports.
// Keeps its own size registers and element stores and predicts every row of results.
// Depends on mm_pkg for widths, command codes and register indexes.
module mm_checker import mm_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_o,
  input  logic [CMD_W-1:0]          cmd_i,
  input  logic [IDX_W-1:0]          row_i,
  input  logic [IDX_W-1:0]          col_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      out_valid_o,
  input  logic                      out_ready_i,
  input  logic [IDX_W-1:0]          out_row_o,
  input  logic [IDX_W-1:0]          out_col_o,
  input  logic signed [SUM_W-1:0]   out_value_o,
  input  logic                      last_o,
  input  logic                      cfg_we_i,
  input  logic [REG_IDX_W-1:0]      cfg_index_i,
  input  logic [SIZE_W-1:0]         cfg_wdata_i,
  output int                        mismatches_o,
  output int                        pending_o,
  output int                        checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [SUM_W-1:0] value;
    logic                    last;
  } dot_t;

  logic [SIZE_W-1:0]     rows_a_q;
  logic [SIZE_W-1:0]     inner_len_q;
  logic [SIZE_W-1:0]     cols_b_q;
  logic [DATA_WIDTH-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic [DATA_WIDTH-1:0] b_mem [MAX_DIM*MAX_DIM];
  dot_t                  dot_q [$];

  function automatic int clip(input int v, input int cap);
    return (v > cap) ? cap : v;
  endfunction

  // Queues one dot product per result column of row r, as the block emits them.
  task automatic predict_row(input logic [IDX_W-1:0] r);
    int     nr;
    int     nk;
    int     nc;
    longint acc;
    longint ea;
    longint eb;
    dot_t   d;
    nr = clip(rows_a_q, MAX_DIM);
    nk = clip(inner_len_q, MAX_DIM);
    nc = clip(clip(cols_b_q, MAX_DIM), MAX_RESULTS);
    if (r >= nr) return;
    for (int j = 0; j < nc; j++) begin
      acc = 0;
      for (int k = 0; k < nk; k++) begin
        ea = $signed(a_mem[r*MAX_DIM + k]);
        eb = $signed(b_mem[k*MAX_DIM + j]);
        acc += ea * eb;
      end
      d.row   = r;
      d.col   = IDX_W'(j);
      d.value = acc[SUM_W-1:0];
      d.last  = (j == nc - 1);
      dot_q.push_back(d);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [63:0] wide;
    dot_t               want;
    if (!rst_ni) begin
      rows_a_q     = 5'd16;
      inner_len_q  = 5'd16;
      cols_b_q     = 5'd16;
      dot_q.delete();
      mismatches_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ROWS_A:    rows_a_q    = cfg_wdata_i;
          REG_INNER_LEN: inner_len_q = cfg_wdata_i;
          REG_COLS_B:    cols_b_q    = cfg_wdata_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_o) begin
        case (cmd_i)
          CMD_LOAD_A, CMD_LOAD_B: begin
            if (row_i < MAX_DIM && col_i < MAX_DIM) begin
              wide = value_i;
              if (cmd_i == CMD_LOAD_A) begin
                a_mem[row_i*MAX_DIM + col_i] = wide[DATA_WIDTH-1:0];
              end else begin
                b_mem[row_i*MAX_DIM + col_i] = wide[DATA_WIDTH-1:0];
              end
            end
          end
          CMD_COMPUTE: predict_row(row_i);
          default: ;
        endcase
      end

      if (out_valid_o && out_ready_i) begin
        if (dot_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10) begin
            $display("%0t: unexpected result item row %0d col %0d value %0d last %0b",
                     $realtime, out_row_o, out_col_o, out_value_o, last_o);
          end
        end else begin
          want = dot_q.pop_front();
          checked_o++;
          if (want.row !== out_row_o || want.col !== out_col_o ||
              want.value !== out_value_o || want.last !== last_o) begin
            mismatches_o++;
            if (mismatches_o <= 10) begin
              $display("%0t: result mismatch, expected row %0d col %0d value %0d last %0b",
                       $realtime, want.row, want.col, want.value, want.last);
              $display("%0t:                  got      row %0d col %0d value %0d last %0b",
                       $realtime, out_row_o, out_col_o, out_value_o, last_o);
            end
          end
        end
      end
      pending_o = dot_q.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
// Top of the matrix multiply testbench: clock, reset, stimulus, output stalls and verdict.
// Instantiates matrix_multiply as i_dut and mm_checker beside it.
// Depends on mm_pkg for widths, command codes and register indexes.
module tb import mm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Command code 3 has no meaning in the block; it must be dropped silently.
  localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
  // Register index 3 selects no register; a write there must change nothing.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Longest compute walk (full 16 x 16 row) with some margin. Used as the quiet
  // time before a size change and at the end.
  localparam int WALK_CYCLES    = 1 + MAX_DIM_DEF * (MAX_DIM_DEF + 3) + 16;
  // The longest stretch with no handshake in a correct run is little over one quiet time.
  localparam int WATCHDOG_LIMIT = 6 * WALK_CYCLES;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [CMD_W-1:0]          cmd_i;
  logic [IDX_W-1:0]          row_i;
  logic [IDX_W-1:0]          col_i;
  logic signed [VALUE_W-1:0] value_i;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [IDX_W-1:0]          out_row_o;
  logic [IDX_W-1:0]          out_col_o;
  logic signed [SUM_W-1:0]   out_value_o;
  logic                      last_o;
  logic                      cfg_we_i;
  logic [REG_IDX_W-1:0]      cfg_index_i;
  logic [SIZE_W-1:0]         cfg_wdata_i;

  int mismatches;
  int pending;
  int results_checked;

  always #5 clk_i = ~clk_i;

  matrix_multiply i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_value_o (out_value_o),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  mm_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .out_value_o  (out_value_o),
    .last_o       (last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (results_checked)
  );

  // ---------------------------------------------------------------------------
  // Output side. The ready pattern steps through three modes in turn, the last one
  // held twice as long: always ready, randomly ready with probability 3/4, and
  // sparse stall bursts. Since the pattern period is unrelated to the compute
  // walk length, stalls land on every step of the emit sequence over the run.
  // ---------------------------------------------------------------------------
  logic [7:0] ready_phase = '0;
  int         stall_left  = 0;

  always @(negedge clk_i) begin
    ready_phase <= ready_phase + 8'd1;
    case (ready_phase[7:6])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          out_ready_i <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 11);
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a correct run never goes much longer than a quiet time without
  // some handshake, so a long silence means the block has hung.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a handshake", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus bookkeeping. The element stores come out of reset holding garbage,
  // so the sender remembers which entries it has written and never lets a
  // compute read one that was not. Stores keep their contents across size
  // changes, so entries filled in one setting serve the later ones too.
  // ---------------------------------------------------------------------------
  bit a_written [MAX_DIM_DEF][MAX_DIM_DEF];
  bit b_written [MAX_DIM_DEF][MAX_DIM_DEF];
  int nr;             // effective sizes after saturation, as the block sees them
  int nk;
  int nc;
  int items_sent;     // accepted loads and computes
  int loads_sent;
  int computes_sent;
  int unused_sent;
  int settings_used;
  int burst_left;

  function automatic int saturate(input int v);
    return (v > MAX_DIM_DEF) ? MAX_DIM_DEF : v;
  endfunction

  // Element values lean on the corners of the Q8.8 range.
  function automatic logic [VALUE_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Mostly an index inside the active size, sometimes anywhere in the store.
  function automatic logic [IDX_W-1:0] pick_index(input int n);
    if (n > 0 && $urandom_range(0, 4) != 0) return IDX_W'($urandom_range(0, n - 1));
    return IDX_W'($urandom_range(0, 15));
  endfunction

  // Presents one item and returns at the falling edge after it was taken.
  // The sender runs in bursts; before a new burst valid may drop for a gap.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c, input logic [VALUE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    row_i      <= r;
    col_i      <= c;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);

    case (cmd)
      CMD_LOAD_A: begin
        a_written[r][c] = 1'b1;
        loads_sent++;
      end
      CMD_LOAD_B: begin
        b_written[r][c] = 1'b1;
        loads_sent++;
      end
      CMD_COMPUTE: computes_sent++;
      default: unused_sent++;
    endcase
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // A compute for an in-range row reads row r of A over the inner length and
  // the top-left inner x cols block of B; any entry there not yet written is
  // loaded with random content first. The ignored col and value fields of the
  // compute get random bits so the block is seen to ignore them.
  task automatic compute_row(input logic [IDX_W-1:0] r);
    if (r < nr && nc != 0) begin
      for (int k = 0; k < nk; k++) begin
        if (!a_written[r][k]) send_item(CMD_LOAD_A, r, IDX_W'(k), rand_elem());
      end
      for (int k = 0; k < nk; k++) begin
        for (int j = 0; j < nc; j++) begin
          if (!b_written[k][j]) send_item(CMD_LOAD_B, IDX_W'(k), IDX_W'(j), rand_elem());
        end
      end
    end
    send_item(CMD_COMPUTE, r, IDX_W'($urandom), VALUE_W'($urandom));
  endtask

  // Size changes happen only with the block idle: every expected result has
  // come back and a full walk time has passed.
  task automatic configure(input int rows, input int inner, input int cols,
                           input bit touch_unused);
    while (pending != 0) @(negedge clk_i);
    repeat (WALK_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_ROWS_A;
    cfg_wdata_i <= SIZE_W'(rows);
    @(negedge clk_i);
    cfg_index_i <= REG_INNER_LEN;
    cfg_wdata_i <= SIZE_W'(inner);
    @(negedge clk_i);
    cfg_index_i <= REG_COLS_B;
    cfg_wdata_i <= SIZE_W'(cols);
    @(negedge clk_i);
    if (touch_unused) begin
      cfg_index_i <= REG_UNUSED;
      cfg_wdata_i <= SIZE_W'($urandom);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    nr = saturate(rows);
    nk = saturate(inner);
    nc = saturate(cols);
    settings_used++;
  endtask

  // Random traffic for one size setting. Loads aim mostly at the active part of
  // the stores and computes mostly at valid rows, so most computes are whole
  // load-then-compute sequences; a few stray indices and unused commands mix in.
  task automatic random_phase(input int budget);
    int stop_at;
    int pick;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_item(CMD_LOAD_A, pick_index(nr), pick_index(nk), rand_elem());
      end else if (pick < 72) begin
        send_item(CMD_LOAD_B, pick_index(nk), pick_index(nc), rand_elem());
      end else if (pick < 95) begin
        compute_row(pick_index(nr));
      end else begin
        send_item(CMD_UNUSED, IDX_W'($urandom), IDX_W'($urandom), VALUE_W'($urandom));
      end
    end
    in_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    // Fixed settings: unit size, the full 16 x 16 case, each size register at
    // zero, all registers above the store size (saturation) and a mixed shape.
    int phase_rows  [7] = '{1, 16, 0, 4, 5, 31, 7};
    int phase_inner [7] = '{1, 16, 5, 0, 3, 31, 4};
    int phase_cols  [7] = '{1, 16, 4, 3, 0, 31, 6};
    int phase_items [7] = '{20, 210, 15, 20, 15, 25, 40};

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = CMD_LOAD_A;
    row_i         = '0;
    col_i         = '0;
    value_i       = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_ROWS_A;
    cfg_wdata_i   = '0;
    nr            = MAX_DIM_DEF;
    nk            = MAX_DIM_DEF;
    nc            = MAX_DIM_DEF;
    items_sent    = 0;
    loads_sent    = 0;
    computes_sent = 0;
    unused_sent   = 0;
    settings_used = 0;
    burst_left    = 0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part on a 3 x 2 times 2 x 3 product. A and B hold the corners
    // of the element range, so row 1 gives the largest positive sum
    // (2 x (-128.0 x -128.0)) and row 0 mixes the extremes.
    configure(3, 2, 3, 1'b0);
    send_item(CMD_LOAD_A, 4'd0, 4'd0, 16'h7fff);
    send_item(CMD_LOAD_A, 4'd0, 4'd1, 16'h8000);
    send_item(CMD_LOAD_A, 4'd1, 4'd0, 16'h8000);
    send_item(CMD_LOAD_A, 4'd1, 4'd1, 16'h8000);
    send_item(CMD_LOAD_A, 4'd2, 4'd0, 16'hffff);
    send_item(CMD_LOAD_A, 4'd2, 4'd1, 16'h0000);
    send_item(CMD_LOAD_B, 4'd0, 4'd0, 16'h7fff);
    send_item(CMD_LOAD_B, 4'd0, 4'd1, 16'h8000);
    send_item(CMD_LOAD_B, 4'd0, 4'd2, 16'h0001);
    send_item(CMD_LOAD_B, 4'd1, 4'd0, 16'h8000);
    send_item(CMD_LOAD_B, 4'd1, 4'd1, 16'h8000);
    send_item(CMD_LOAD_B, 4'd1, 4'd2, 16'hffff);
    compute_row(4'd0);
    compute_row(4'd1);
    compute_row(4'd2);
    // Row 3 is past rows_a, so nothing comes out.
    compute_row(4'd3);
    // The unused command code must leave the stores and the output alone.
    send_item(CMD_UNUSED, 4'd15, 4'd15, 16'h5a5a);
    // Loads at the far corner of both stores.
    send_item(CMD_LOAD_A, 4'd15, 4'd15, 16'h8000);
    send_item(CMD_LOAD_B, 4'd15, 4'd15, 16'h7fff);
    compute_row(4'd2);
    in_valid_i <= 1'b0;

    for (int p = 0; p < 7; p++) begin
      // The mixed-shape setting also pokes the unused register index.
      configure(phase_rows[p], phase_inner[p], phase_cols[p], p == 6);
      random_phase(phase_items[p]);
    end

    // A few small random shapes to finish.
    repeat (3) begin
      configure($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8), 1'b0);
      random_phase(25);
    end

    // Drain: every expected result back, then a full walk time for any
    // stray output.
    while (pending != 0) @(negedge clk_i);
    repeat (WALK_CYCLES) @(negedge clk_i);

    $display("Sent %0d loads, %0d computes and %0d unused commands over %0d size settings.",
             loads_sent, computes_sent, unused_sent, settings_used);
    $display("Checked %0d result items, %0d mismatching, %0d still outstanding.",
             results_checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- matrix_multiply.f -----
hdl/mm_pkg.sv
hdl/mm_ctrl.sv
hdl/mm_dp.sv
hdl/matrix_multiply.sv
verif/mm_checker.sv
verif/tb.sv
